>>> hw/rtl/tcfv_pkg.sv
// Shared types and constants of the TCP over IPv4 frame checksum verifier.
package tcfv_pkg;

	localparam int unsigned MAX_FRAME_BYTES_DEF = 65535;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [3:0]  IP_VERSION_4   = 4'd4;

	typedef enum logic [2:0] {
		ST_TCP_OK,
		ST_CSUM_BAD,
		ST_RUNT,
		ST_NOT_IPV4,
		ST_BAD_IP_HDR,
		ST_ZERO_ADDR,
		ST_NOT_TCP,
		ST_BAD_TCP_LEN
	} status_t;

	typedef struct packed {
		logic [15:0] flen;
		logic [3:0]  ihl;
		logic [15:0] tot_len;
		logic [15:0] ether;
		logic [3:0]  ver;
		logic [7:0]  proto;
		logic [1:0]  addr_nz;
		logic [3:0]  tcp_off;
		logic [15:0] ones_sum;
		logic [7:0]  held;
		logic [15:0] seglen;
	} frame_snap_t;

endpackage

>>> hw/rtl/tcfv_byte_parser.sv
// Input register, per-byte header capture and running ones-complement sum, frame snapshot.
module tcfv_byte_parser #(
	parameter int unsigned MAX_FRAME_BYTES = tcfv_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	output logic                  snap_valid,
	input  logic                  snap_ready,
	output tcfv_pkg::frame_snap_t snap
);

	localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

	localparam logic [16:0] OFS_TYPE_HI  = 17'd12;
	localparam logic [16:0] OFS_TYPE_LO  = 17'd13;
	localparam logic [16:0] OFS_VER_IHL  = 17'd14;
	localparam logic [16:0] OFS_TLEN_HI  = 17'd16;
	localparam logic [16:0] OFS_TLEN_LO  = 17'd17;
	localparam logic [16:0] OFS_PROTO    = 17'd23;
	localparam logic [16:0] OFS_SRC_ADDR = 17'd26;
	localparam logic [16:0] OFS_DST_ADDR = 17'd30;
	localparam logic [16:0] OFS_ADDR_END = 17'd33;
	localparam logic [16:0] OFS_IP_HDR   = 17'd34;
	localparam logic [16:0] ETH_HDR_LEN  = 17'd14;
	localparam logic [16:0] TCP_OFF_POS  = 17'd12;

	function automatic logic [15:0] add_fold(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = 17'(a) + 17'(b);
		return s[15:0] + 16'(s[16]);
	endfunction

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             move_s1;

	logic [POS_W-1:0] pos_q,     d_pos;
	logic [3:0]       ihl_q,     d_ihl;
	logic [15:0]      tot_len_q, d_tot_len;
	logic [15:0]      ether_q,   d_ether;
	logic [3:0]       ver_q,     d_ver;
	logic [7:0]       proto_q,   d_proto;
	logic [1:0]       addr_nz_q, d_addr_nz;
	logic [3:0]       tcp_off_q, d_tcp_off;
	logic [15:0]      sum_q,     d_sum;
	logic [7:0]       held_q,    d_held;

	logic [16:0]      pos17;
	logic [16:0]      seg_start;
	logic [16:0]      seg_end;
	logic             snap_valid_s2;
	tcfv_pkg::frame_snap_t snap_s2;

	assign move_s1  = valid_s1 && (!last_s1 || !snap_valid_s2 || snap_ready);
	assign in_ready = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	assign pos17     = 17'(pos_q);
	assign seg_start = ETH_HDR_LEN + 17'({ihl_q, 2'b00});
	assign seg_end   = ETH_HDR_LEN + 17'(tot_len_q);

	always_comb begin
		d_pos     = pos_q;
		d_ihl     = ihl_q;
		d_tot_len = tot_len_q;
		d_ether   = ether_q;
		d_ver     = ver_q;
		d_proto   = proto_q;
		d_addr_nz = addr_nz_q;
		d_tcp_off = tcp_off_q;
		d_sum     = sum_q;
		d_held    = held_q;
		if (pos_q < POS_MAX) begin
			d_pos = pos_q + POS_W'(1);
			if (pos17 == OFS_TYPE_HI) begin
				d_ether = {byte_s1, 8'h00};
			end else if (pos17 == OFS_TYPE_LO) begin
				d_ether = {ether_q[15:8], byte_s1};
			end else if (pos17 == OFS_VER_IHL) begin
				d_ver = byte_s1[7:4];
				d_ihl = byte_s1[3:0];
			end else if (pos17 == OFS_TLEN_HI) begin
				d_tot_len = {byte_s1, 8'h00};
			end else if (pos17 == OFS_TLEN_LO) begin
				d_tot_len = {tot_len_q[15:8], byte_s1};
			end else if (pos17 == OFS_PROTO) begin
				d_proto = byte_s1;
			end else if (pos17 >= OFS_SRC_ADDR && pos17 <= OFS_ADDR_END) begin
				if (byte_s1 != 8'h00) begin
					if (pos17 < OFS_DST_ADDR) begin
						d_addr_nz[0] = 1'b1;
					end else begin
						d_addr_nz[1] = 1'b1;
					end
				end
				if (!pos17[0]) begin
					d_held = byte_s1;
				end else begin
					d_sum = add_fold(sum_q, {held_q, byte_s1});
				end
			end else if (pos17 >= OFS_IP_HDR && ihl_q >= 4'd5 &&
					pos17 >= seg_start && pos17 < seg_end) begin
				if (pos17 == seg_start + TCP_OFF_POS) begin
					d_tcp_off = byte_s1[7:4];
				end
				if (!pos17[0]) begin
					d_held = byte_s1;
				end else begin
					d_sum = add_fold(sum_q, {held_q, byte_s1});
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			ihl_q     <= '0;
			tot_len_q <= '0;
			ether_q   <= '0;
			ver_q     <= '0;
			proto_q   <= '0;
			addr_nz_q <= '0;
			tcp_off_q <= '0;
			sum_q     <= '0;
			held_q    <= '0;
		end else if (move_s1) begin
			if (last_s1) begin
				pos_q     <= '0;
				ihl_q     <= '0;
				tot_len_q <= '0;
				ether_q   <= '0;
				ver_q     <= '0;
				proto_q   <= '0;
				addr_nz_q <= '0;
				tcp_off_q <= '0;
				sum_q     <= '0;
				held_q    <= '0;
			end else begin
				pos_q     <= d_pos;
				ihl_q     <= d_ihl;
				tot_len_q <= d_tot_len;
				ether_q   <= d_ether;
				ver_q     <= d_ver;
				proto_q   <= d_proto;
				addr_nz_q <= d_addr_nz;
				tcp_off_q <= d_tcp_off;
				sum_q     <= d_sum;
				held_q    <= d_held;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (!snap_valid_s2 || snap_ready) begin
			snap_valid_s2 <= move_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && last_s1) begin
			snap_s2.flen     <= 16'(d_pos);
			snap_s2.ihl      <= d_ihl;
			snap_s2.tot_len  <= d_tot_len;
			snap_s2.ether    <= d_ether;
			snap_s2.ver      <= d_ver;
			snap_s2.proto    <= d_proto;
			snap_s2.addr_nz  <= d_addr_nz;
			snap_s2.tcp_off  <= d_tcp_off;
			snap_s2.ones_sum <= d_sum;
			snap_s2.held     <= d_held;
			snap_s2.seglen   <= d_tot_len - 16'({d_ihl, 2'b00});
		end
	end

	assign snap_valid = snap_valid_s2;
	assign snap       = snap_s2;

endmodule

>>> hw/rtl/tcfv_result_check.sv
// Frame checks, pseudo-header completion, checksum fold and the output register.
module tcfv_result_check (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  snap_valid,
	output logic                  snap_ready,
	input  tcfv_pkg::frame_snap_t snap,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tcfv_pkg::status_t     out_status,
	output logic [15:0]           out_checksum,
	output logic [15:0]           out_seglen
);

	logic              out_valid_q;
	tcfv_pkg::status_t status_q;
	logic [15:0]       chk_q;
	logic [15:0]       seglen_q;

	tcfv_pkg::status_t status_d;
	logic [15:0]       chk_d;
	logic [15:0]       seglen_d;

	logic [16:0]       flen17;
	logic [15:0]       hlen;
	logic [15:0]       pad;
	logic [17:0]       sum18;
	logic [16:0]       fold1;
	logic [15:0]       fold2;
	logic [15:0]       chk_full;
	logic              ip_bad;
	logic              tcp_len_bad;

	assign flen17 = 17'(snap.flen);
	assign hlen   = 16'({snap.ihl, 2'b00});
	assign pad    = snap.seglen[0] ? {snap.held, 8'h00} : 16'h0000;
	assign sum18  = 18'(snap.ones_sum) + 18'(pad) + 18'(tcfv_pkg::PROTO_TCP) + 18'(snap.seglen);
	assign fold1  = 17'(sum18[15:0]) + 17'(sum18[17:16]);
	assign fold2  = fold1[15:0] + 16'(fold1[16]);
	assign chk_full = ~fold2;

	assign ip_bad = (flen17 < 17'd34) || (snap.ihl < 4'd5) ||
		(snap.ver != tcfv_pkg::IP_VERSION_4) ||
		(17'(snap.tot_len) + 17'd14 > flen17) || (snap.tot_len < hlen);
	assign tcp_len_bad = (snap.seglen < 16'd20) ||
		(snap.seglen < 16'({snap.tcp_off, 2'b00}));

	always_comb begin
		chk_d    = 16'h0000;
		seglen_d = 16'h0000;
		if (flen17 < 17'd14) begin
			status_d = tcfv_pkg::ST_RUNT;
		end else if (snap.ether != tcfv_pkg::ETHERTYPE_IPV4) begin
			status_d = tcfv_pkg::ST_NOT_IPV4;
		end else if (ip_bad) begin
			status_d = tcfv_pkg::ST_BAD_IP_HDR;
		end else begin
			seglen_d = snap.seglen;
			if (snap.addr_nz != 2'b11) begin
				status_d = tcfv_pkg::ST_ZERO_ADDR;
			end else if (snap.proto != tcfv_pkg::PROTO_TCP) begin
				status_d = tcfv_pkg::ST_NOT_TCP;
			end else if (tcp_len_bad) begin
				status_d = tcfv_pkg::ST_BAD_TCP_LEN;
			end else begin
				chk_d    = chk_full;
				status_d = (chk_full == 16'h0000) ? tcfv_pkg::ST_TCP_OK : tcfv_pkg::ST_CSUM_BAD;
			end
		end
	end

	assign snap_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap_ready) begin
			out_valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			status_q <= status_d;
			chk_q    <= chk_d;
			seglen_q <= seglen_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_status   = status_q;
	assign out_checksum = chk_q;
	assign out_seglen   = seglen_q;

endmodule

>>> hw/rtl/tcp_ipv4_frame_checksum_verifier_top.sv
// Top level of the TCP over IPv4 frame checksum verifier.
// The slave stream carries an Ethernet frame one byte per transaction in wire order,
// with s_tlast on the final byte. The block captures the Ethernet and IPv4 header fields,
// sums the addresses and the TCP segment in ones-complement arithmetic and, for each
// frame, sends one transaction on the master stream with the status, the checksum
// result and the TCP segment length.
// A byte is taken every cycle while the result path is not stalled; the frame bytes pass
// through an input register, the header capture and sum update work on one byte per
// cycle, and the final byte loads a frame snapshot register. The checks and the checksum
// fold then fill the output register, and m_tvalid rises when the result is loaded there.
// Throughput is one byte per cycle while m_tready does not hold the flow, with no gap between frames.
// Reset clears all valid flags and the per-frame state; a frame in flight and any result
// not yet taken are dropped. When the receiver holds m_tready low, the output register
// and the snapshot register each keep one result, and bytes are still taken until the
// last byte of the next frame sits in the input register; s_tready then stays low until
// the output register empties.
module tcp_ipv4_frame_checksum_verifier_top #(
	parameter int unsigned MAX_FRAME_BYTES = tcfv_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [2:0] status, [18:3] checksum_result, [34:19] segment_length
);

	logic                  snap_valid;
	logic                  snap_ready;
	tcfv_pkg::frame_snap_t snap;
	tcfv_pkg::status_t     status;
	logic [15:0]           checksum_result;
	logic [15:0]           segment_length;

	tcfv_byte_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.snap_valid(snap_valid),
		.snap_ready(snap_ready),
		.snap      (snap)
	);

	tcfv_result_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.snap_valid  (snap_valid),
		.snap_ready  (snap_ready),
		.snap        (snap),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (status),
		.out_checksum(checksum_result),
		.out_seglen  (segment_length)
	);

	assign m_tdata = {5'b00000, segment_length, checksum_result, status};

`ifndef SYNTHESIS
	a_chk_only_for_tcp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status != tcfv_pkg::ST_TCP_OK && status != tcfv_pkg::ST_CSUM_BAD)
		|-> (checksum_result == 16'h0000))
		else $error("checksum result set for a frame that was not checked");
	a_seglen_zero_on_hdr_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (status == tcfv_pkg::ST_RUNT || status == tcfv_pkg::ST_NOT_IPV4 ||
		status == tcfv_pkg::ST_BAD_IP_HDR)) |-> (segment_length == 16'h0000))
		else $error("segment length set for a frame with a bad header");
	a_bad_csum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status == tcfv_pkg::ST_CSUM_BAD) |-> (checksum_result != 16'h0000))
		else $error("checksum reported bad with a zero result");
	a_tcp_seglen_min: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (status == tcfv_pkg::ST_TCP_OK || status == tcfv_pkg::ST_CSUM_BAD))
		|-> (segment_length >= 16'd20))
		else $error("checked segment shorter than a TCP header");
`endif

endmodule
